// File: rtl/ddo_pkg.sv
package ddo_pkg;

    localparam int ANGLE_BITS = 32;
    localparam int TRIG_STEPS = 16;
    localparam int STEP_BITS  = 5;

    localparam logic [31:0] DEG_TO_RAD_Q32  = 32'd74961321;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic signed [63:0] ARC_LIMIT = 64'sd68719476736;

    localparam logic [8:0]  DEG_PER_TURN = 9'd360;
    localparam logic [30:0] RECIP_45     = 31'd1527099484;
    localparam logic [31:0] RECIP_3      = 32'd2863311531;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_INV_AXLE = 2'd1;
    localparam logic [1:0] CFG_SWAP = 2'd2;

    typedef struct packed {
        logic load;
        logic gain_mul;
        logic gain_div;
        logic delta;
        logic arc_mul;
        logic arc_scale;
        logic turn_mul;
        logic trig_start;
        logic trig_step;
        logic trig_save;
        logic sum_div;
        logic x_mul;
        logic y_mul;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic trig_last;
        logic div_last;
        logic [1:0] trig_idx;
    } t_status;

    function automatic logic [31:0] atan_val(input logic [STEP_BITS-1:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
            5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
            5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
            5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
            5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
            5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
            5'd20: r = 32'd652;       5'd21: r = 32'd326;
            5'd22: r = 32'd163;       5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] angle_mask();
        logic [31:0] m;
        m = '1;
        for (int k = 0; k < 32 - ANGLE_BITS; k++) m[k] = 1'b0;
        return m;
    endfunction

endpackage

// File: rtl/ddo_if.sv
interface ddo_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    modport source (output valid, left_count, right_count, input ready);
    modport sink (input valid, left_count, right_count, output ready);
endinterface

interface ddo_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0] heading;
    modport source (output valid, pos_x, pos_y, heading, input ready);
    modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

// File: rtl/ddo_ctrl.sv
module ddo_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  ddo_pkg::t_status i_status,
    output ddo_pkg::t_cmd o_cmd
);
    import ddo_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_GMUL  = 14'b00000000000010,
        S_GDIV  = 14'b00000000000100,
        S_DELTA = 14'b00000000001000,
        S_AMUL  = 14'b00000000010000,
        S_ASCL  = 14'b00000000100000,
        S_TURN  = 14'b00000001000000,
        S_TSTA  = 14'b00000010000000,
        S_TSTEP = 14'b00000100000000,
        S_TSAVE = 14'b00001000000000,
        S_SDIV  = 14'b00010000000000,
        S_XMUL  = 14'b00100000000000,
        S_YMUL  = 14'b01000000000000,
        S_COMM  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid;
        o_cmd = '0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state = S_GMUL;
                end
            end
            S_GMUL: begin
                o_cmd.gain_mul = 1'b1;
                n_state = S_GDIV;
            end
            S_GDIV: begin
                o_cmd.gain_div = 1'b1;
                if (i_status.div_last) n_state = S_DELTA;
            end
            S_DELTA: begin
                o_cmd.delta = 1'b1;
                n_state = S_AMUL;
            end
            S_AMUL: begin
                o_cmd.arc_mul = 1'b1;
                n_state = S_ASCL;
            end
            S_ASCL: begin
                o_cmd.arc_scale = 1'b1;
                n_state = S_TURN;
            end
            S_TURN: begin
                o_cmd.turn_mul = 1'b1;
                n_state = S_TSTA;
            end
            S_TSTA: begin
                o_cmd.trig_start = 1'b1;
                n_state = S_TSTEP;
            end
            S_TSTEP: begin
                o_cmd.trig_step = 1'b1;
                if (i_status.trig_last) n_state = S_TSAVE;
            end
            S_TSAVE: begin
                o_cmd.trig_save = 1'b1;
                if (i_status.trig_idx == 2'd2) n_state = S_SDIV;
                else n_state = S_TSTA;
            end
            S_SDIV: begin
                o_cmd.sum_div = 1'b1;
                if (i_status.div_last) n_state = S_XMUL;
            end
            S_XMUL: begin
                o_cmd.x_mul = 1'b1;
                n_state = S_YMUL;
            end
            S_YMUL: begin
                o_cmd.y_mul = 1'b1;
                n_state = S_COMM;
            end
            S_COMM: begin
                o_cmd.commit = 1'b1;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// File: rtl/ddo_datapath.sv
module ddo_datapath (
    input  logic i_clk,
    input  logic i_rst_n,
    input  ddo_pkg::t_cmd i_cmd,
    output ddo_pkg::t_status o_status,
    input  logic i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic [31:0] i_left_count,
    input  logic [31:0] i_right_count,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic [31:0] o_heading
);
    import ddo_pkg::*;

    logic [23:0] r_radius, r_inv_axle;
    logic r_swap;
    logic [31:0] r_last_l, r_last_r, r_heading;
    logic [47:0] r_acc_x, r_acc_y;

    logic [47:0] r_ri;
    logic [1:0]  r_cnt;
    // divide by 360 one 24-bit digit per beat by reciprocal multiply
    logic [63:0] r_quo;
    logic [8:0]  r_rem;
    logic [63:0] r_gain;
    logic signed [32:0] r_dl, r_dr;
    logic signed [63:0] r_dsr;
    logic signed [31:0] r_arc2;
    logic [32:0] r_tlo;
    logic [31:0] r_full, r_half;
    logic signed [32:0] r_cx, r_cy;
    logic signed [33:0] r_z;
    logic r_flip;
    logic [4:0] r_step;
    logic [1:0] r_tidx;
    logic signed [35:0] r_sc, r_ss;
    logic signed [34:0] r_wx, r_wy;
    logic signed [47:0] r_px, r_py;

    logic signed [33:0] dl_s, dr_s, ds, dd;
    logic signed [58:0] dsr_c;
    logic signed [65:0] arc_c;
    logic signed [66:0] tpart_c;
    logic [32:0] turn_sum;
    logic [23:0] digit;
    logic [32:0] num;
    logic [60:0] qprod;
    logic [23:0] qdig;
    logic [32:0] rem_c;
    logic signed [35:0] sum_sel, sum_mag;
    logic [63:0] wprod;
    logic signed [34:0] w_c;
    logic signed [66:0] p_c;
    logic [31:0] ang, ang_f;
    logic signed [32:0] sh_x, sh_y;
    logic signed [35:0] term, term_y;

    assign o_status.trig_last = (r_step == 5'(TRIG_STEPS - 1));
    assign o_status.div_last  = (r_cnt == 2'd0);
    assign o_status.trig_idx  = r_tidx;

    always_comb begin
        if (r_swap) begin
            dl_s = 34'(r_dr); dr_s = 34'(r_dl);
        end else begin
            dl_s = 34'(r_dl); dr_s = 34'(r_dr);
        end
        ds = dl_s + dr_s;
        dd = dr_s - dl_s;
        dsr_c = ds * $signed({1'b0, r_radius});
        arc_c = $signed(r_dsr[37:0]) * $signed({1'b0, DEG_TO_RAD_Q32[26:0]});
        tpart_c = dd * $signed({1'b0, i_cmd.turn_mul ? r_gain[63:32] : r_gain[31:0]});
        turn_sum = r_tlo + tpart_c[32:0];
        unique case (r_cnt)
            2'd2: digit = r_ri[47:24];
            2'd1: digit = r_ri[23:0];
            default: digit = 24'd0;
        endcase
        num = {r_rem, digit};
        qprod = num[32:3] * RECIP_45;
        qdig = qprod[59:36];
        rem_c = num - 33'(qdig) * 33'(DEG_PER_TURN);
        sum_sel = (r_cnt == 2'd1) ? r_sc : r_ss;
        sum_mag = sum_sel[35] ? -sum_sel : sum_sel;
        wprod = sum_mag[32:1] * RECIP_3;
        w_c = sum_sel[35] ? -35'(wprod[63:33]) : 35'(wprod[63:33]);
        p_c = r_arc2 * (i_cmd.y_mul ? r_wy : r_wx);
        unique case (r_tidx)
            2'd0: ang = r_heading;
            2'd1: ang = r_heading + r_half;
            default: ang = r_heading + r_full;
        endcase
        ang = ang & angle_mask();
        ang_f = ang + 32'h4000_0000;
        sh_x = r_cx >>> r_step;
        sh_y = r_cy >>> r_step;
        term = r_flip ? -36'(r_cx) : 36'(r_cx);
        term_y = r_flip ? -36'(r_cy) : 36'(r_cy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 24'd183501;
            r_inv_axle <= 24'd1497965;
            r_swap <= 1'b0;
            r_last_l <= '0;
            r_last_r <= '0;
            r_heading <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_cnt <= '0;
            r_step <= '0;
            r_tidx <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RADIUS: r_radius <= i_cfg_data;
                    CFG_INV_AXLE: r_inv_axle <= i_cfg_data;
                    CFG_SWAP: r_swap <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_dl <= 33'($signed(i_left_count - r_last_l));
                r_dr <= 33'($signed(i_right_count - r_last_r));
                r_last_l <= i_left_count;
                r_last_r <= i_right_count;
            end
            if (i_cmd.gain_mul) begin
                r_ri <= 48'(r_radius) * 48'(r_inv_axle);
                r_rem <= '0;
                r_cnt <= 2'd2;
            end
            if (i_cmd.gain_div) begin
                r_rem <= rem_c[8:0];
                r_quo <= {r_quo[39:0], qdig};
                if (r_cnt != 2'd0) r_cnt <= r_cnt - 2'd1;
            end
            if (i_cmd.delta) begin
                r_gain <= r_quo;
                r_dsr <= 64'(dsr_c);
            end
            if (i_cmd.arc_mul) begin
                if (r_dsr > ARC_LIMIT) r_dsr <= ARC_LIMIT;
                else if (r_dsr < -ARC_LIMIT) r_dsr <= -ARC_LIMIT;
                r_tlo <= tpart_c[64:32];
            end
            if (i_cmd.arc_scale) r_arc2 <= 32'(arc_c >>> 32);
            if (i_cmd.turn_mul) begin
                r_full <= turn_sum[31:0];
                r_half <= turn_sum[32:1];
                r_tidx <= 2'd0;
                r_sc <= '0;
                r_ss <= '0;
            end
            if (i_cmd.trig_start) begin
                r_flip <= ang_f[31];
                r_z <= 34'($signed(ang_f[31] ? ang - 32'h8000_0000 : ang));
                r_cx <= 33'(CORDIC_GAIN_Q30);
                r_cy <= '0;
                r_step <= '0;
            end
            if (i_cmd.trig_step) begin
                if (!r_z[33]) begin
                    r_cx <= r_cx - sh_y;
                    r_cy <= r_cy + sh_x;
                    r_z <= r_z - 34'(atan_val(r_step));
                end else begin
                    r_cx <= r_cx + sh_y;
                    r_cy <= r_cy - sh_x;
                    r_z <= r_z + 34'(atan_val(r_step));
                end
                if (r_step != 5'(TRIG_STEPS - 1)) r_step <= r_step + 5'd1;
            end
            if (i_cmd.trig_save) begin
                if (r_tidx == 2'd1) begin
                    r_sc <= r_sc + (term <<< 2);
                    r_ss <= r_ss + (term_y <<< 2);
                end else begin
                    r_sc <= r_sc + term;
                    r_ss <= r_ss + term_y;
                end
                r_tidx <= r_tidx + 2'd1;
                if (r_tidx == 2'd2) r_cnt <= 2'd1;
            end
            if (i_cmd.sum_div) begin
                if (r_cnt == 2'd1) r_wx <= w_c;
                else r_wy <= w_c;
                if (r_cnt != 2'd0) r_cnt <= r_cnt - 2'd1;
            end
            if (i_cmd.x_mul) r_px <= 48'(p_c >>> 31);
            if (i_cmd.y_mul) r_py <= 48'(p_c >>> 31);
            if (i_cmd.commit) begin
                r_acc_x <= r_acc_x + r_px;
                r_acc_y <= r_acc_y + r_py;
                r_heading <= (r_heading + r_full) & angle_mask();
            end
        end
    end

    function automatic logic [31:0] sat(input logic [47:0] v);
        if (!v[47] && v[46:31] != 16'h0000) return 32'h7FFF_FFFF;
        if (v[47] && v[46:31] != 16'hFFFF) return 32'h8000_0000;
        return v[31:0];
    endfunction

    assign o_pos_x = sat(r_acc_x);
    assign o_pos_y = sat(r_acc_y);
    assign o_heading = r_heading;
endmodule

// File: rtl/differential_drive_odometry.sv
// Differential-drive odometry with a Simpson pose update.
// Input channel: one beat carries absolute left and right encoder counts.
// Output channel: one beat per input with X, Y (Q16.16 cm) and heading.
// Configuration: write enable, index and 24-bit data; write only when idle.
// Sequence: a three-digit gain division, the arc and turn steps, three CORDIC
// passes of TRIG_STEPS steps plus start and save, then the weight and pose
// steps. One item at a time: the next input is taken in the cycle after the
// result beat leaves.
// Reset clears the pose, previous counts and restores default registers.
// A stalled receiver holds the result and blocks new input until the result
// beat leaves.
module differential_drive_odometry (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [23:0] i_cfg_data,
    ddo_in_if.sink in_ch,
    ddo_out_if.source out_ch
);
    import ddo_pkg::*;

    t_cmd cmd;
    t_status status;

    ddo_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_status(status), .o_cmd(cmd)
    );

    ddo_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_status(status),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_left_count(in_ch.left_count), .i_right_count(in_ch.right_count),
        .o_pos_x(out_ch.pos_x), .o_pos_y(out_ch.pos_y), .o_heading(out_ch.heading)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.heading))
        else $error("result dropped");
endmodule
